/* rtl/cma_pkg.sv */
// Shared types, constants and the CORDIC arctangent table of the circular mean block.
// Used by cma_front, cma_fifo, cma_back and circular_mean_of_angles.
// No dependencies.
package cma_pkg;

    localparam int TRIG_FRAC_BITS = 15;
    localparam int MAX_SAMPLES    = 1048576;

    localparam int ANGLE_W = 20;
    localparam int MEAN_W  = 13;
    localparam int COUNT_W = 21;
    localparam int SUM_W   = 37;
    localparam int PHASE_W = 32;
    localparam int TRIG_W  = TRIG_FRAC_BITS + 2;

    // CORDIC datapath: Q30 for rotation, normalized 2^59..2^60 for vectoring
    localparam int XY_W   = 64;
    localparam int Z_W    = 34;
    localparam int MAG_W  = 60;
    localparam int ITER_N = (TRIG_FRAC_BITS + 2 > 26) ? 26 : TRIG_FRAC_BITS + 2;
    localparam int ITER_W = 5;

    localparam int FULL_TURN = 5760;

    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (MAX_SAMPLES < 2097151) ? COUNT_W'(MAX_SAMPLES) : {COUNT_W{1'b1}};

    localparam logic [ANGLE_W-1:0] NODATA_RESET = ANGLE_W'(-159984);

    localparam logic signed [XY_W-1:0] CORDIC_START = 64'sd652032874;
    localparam logic signed [Z_W-1:0]  HALF_TURN    = 34'sd2147483648;
    localparam logic signed [Z_W-1:0]  QUARTER_TURN = 34'sd1073741824;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef struct packed {
        logic               last;
        logic               nodata;
        logic [PHASE_W-1:0] phase;
    } cma_item_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] arc_angle(input logic [ITER_W-1:0] idx);
        logic [29:0] val;
        case (idx)
            5'd0:    val = 30'd536870912;
            5'd1:    val = 30'd316933406;
            5'd2:    val = 30'd167458907;
            5'd3:    val = 30'd85004756;
            5'd4:    val = 30'd42667331;
            5'd5:    val = 30'd21354465;
            5'd6:    val = 30'd10679838;
            5'd7:    val = 30'd5340245;
            5'd8:    val = 30'd2670163;
            5'd9:    val = 30'd1335087;
            5'd10:   val = 30'd667544;
            5'd11:   val = 30'd333772;
            5'd12:   val = 30'd166886;
            5'd13:   val = 30'd83443;
            5'd14:   val = 30'd41722;
            5'd15:   val = 30'd20861;
            5'd16:   val = 30'd10430;
            5'd17:   val = 30'd5215;
            5'd18:   val = 30'd2608;
            5'd19:   val = 30'd1304;
            5'd20:   val = 30'd652;
            5'd21:   val = 30'd326;
            5'd22:   val = 30'd163;
            5'd23:   val = 30'd81;
            5'd24:   val = 30'd41;
            5'd25:   val = 30'd20;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/cma_front.sv */
// Front end: accepts sample words, holds the no-data register, classifies each
// sample and turns the angle into a 32-bit phase. Depends on cma_pkg.
module cma_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // [19:0] angle_sample, zero fill above
    input  logic                      s_tlast,   // last_sample
    input  logic                      cfg_we,
    input  logic [cma_pkg::ANGLE_W-1:0] cfg_data,
    output logic                      push,
    output cma_pkg::cma_item_t        push_item,
    input  logic                      q_full
);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MOD  = 5'b00010,
        F_RED  = 5'b00100,
        F_PH   = 5'b01000,
        F_PUSH = 5'b10000
    } fstate_t;

    fstate_t state_reg, state_next;
    logic [cma_pkg::ANGLE_W-1:0] nodata_code_reg;
    logic [cma_pkg::ANGLE_W-1:0] sample_reg;
    logic                        last_reg;
    logic                        nodata_reg;
    logic [20:0]                 shifted_reg;
    logic [8:0]                  quot_reg;
    logic [12:0]                 angle_reg;
    logic [31:0]                 coarse_reg;
    logic [8:0]                  fine_reg;

    logic [20:0] shifted_c;
    logic [41:0] quot_prod;
    logic [20:0] rem_c;
    logic [20:0] rem_fix;
    logic [31:0] coarse_c;
    logic [13:0] fine_num;
    logic [28:0] fine_prod;

    // Offset by a multiple of a full turn so the value is never negative
    assign shifted_c = {sample_reg[cma_pkg::ANGLE_W-1], sample_reg} + 21'd529920;
    // floor(v / 5760) by reciprocal, exact for v below 1641599
    assign quot_prod = 42'(shifted_c) * 42'd1491309;
    assign rem_c     = shifted_reg - 21'(22'(quot_reg) * 22'd5760);
    assign rem_fix   = (rem_c >= 21'd5760) ? rem_c - 21'd5760 : rem_c;
    // round(a * 2^32 / 5760) = a * 745654 + floor((2a + 22) / 45)
    assign coarse_c  = 32'(angle_reg) * 32'd745654;
    assign fine_num  = {angle_reg, 1'b0} + 14'd22;
    assign fine_prod = 29'(fine_num) * 29'd23302;

    assign s_tready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH) && !q_full;

    always_comb
    begin
        push_item.last   = last_reg;
        push_item.nodata = nodata_reg;
        push_item.phase  = coarse_reg + 32'(fine_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (s_tvalid) state_next = F_MOD;
            F_MOD:   state_next = F_RED;
            F_RED:   state_next = F_PH;
            F_PH:    state_next = F_PUSH;
            F_PUSH:  if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= F_IDLE;
            nodata_code_reg <= cma_pkg::NODATA_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                nodata_code_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sample_reg <= s_tdata[cma_pkg::ANGLE_W-1:0];
            last_reg   <= s_tlast;
            nodata_reg <= (s_tdata[cma_pkg::ANGLE_W-1:0] == nodata_code_reg);
        end
        if (state_reg == F_MOD)
        begin
            shifted_reg <= shifted_c;
            quot_reg    <= quot_prod[41:33];
        end
        if (state_reg == F_RED)
            angle_reg <= rem_fix[12:0];
        if (state_reg == F_PH)
        begin
            coarse_reg <= coarse_c;
            fine_reg   <= fine_prod[28:20];
        end
    end

endmodule

/* rtl/cma_fifo.sv */
// Short queue of classified samples between the front end and the CORDIC back end.
// Depends on cma_pkg.
module cma_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cma_pkg::cma_item_t push_item,
    output logic               full,
    input  logic               pop,
    output cma_pkg::cma_item_t pop_item,
    output logic               empty
);

    cma_pkg::cma_item_t entry_reg [cma_pkg::Q_DEPTH];
    logic [cma_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [cma_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [cma_pkg::Q_PTR_W:0]   fill_reg;

    assign full     = (fill_reg == (cma_pkg::Q_PTR_W+1)'(cma_pkg::Q_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* rtl/cma_back.sv */
// Back end: one shared CORDIC rotates each phase into cos/sin, accumulates the
// sums and, on the last word, vectors the sum into the mean. Depends on cma_pkg.
module cma_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  cma_pkg::cma_item_t q_item,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata   // [12:0] mean_angle, [33:13] nodata_count, zero fill
);

    typedef enum logic [7:0] {
        B_IDLE  = 8'b00000001,
        B_ROT   = 8'b00000010,
        B_ACC   = 8'b00000100,
        B_LOAD  = 8'b00001000,
        B_NORM  = 8'b00010000,
        B_VEC   = 8'b00100000,
        B_SCALE = 8'b01000000,
        B_FIN   = 8'b10000000
    } bstate_t;

    localparam logic signed [cma_pkg::SUM_W:0] SUM_MAX = 38'sd68719476735;
    localparam logic signed [cma_pkg::SUM_W:0] SUM_MIN = -38'sd68719476736;

    bstate_t state_reg, state_next;
    logic                                last_reg, last_next;
    logic                                flip_reg, flip_next;
    logic [cma_pkg::ITER_W-1:0]          iter_reg, iter_next;
    logic signed [cma_pkg::XY_W-1:0]     x_reg, x_next;
    logic signed [cma_pkg::XY_W-1:0]     y_reg, y_next;
    logic signed [cma_pkg::Z_W-1:0]      z_reg, z_next;
    logic [cma_pkg::MAG_W-1:0]           mag_reg, mag_next;
    logic signed [cma_pkg::SUM_W-1:0]    cos_sum_reg, cos_sum_next;
    logic signed [cma_pkg::SUM_W-1:0]    sin_sum_reg, sin_sum_next;
    logic [cma_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic [44:0]                         scaled_reg;
    logic                                out_valid_reg, out_valid_next;
    logic [39:0]                         out_data_reg;

    logic signed [cma_pkg::XY_W-1:0] dx, dy, x_step, y_step;
    logic signed [cma_pkg::Z_W-1:0]  arc, z_step, z_fold;
    logic                            turn_up;
    logic                            iter_done;
    logic signed [cma_pkg::TRIG_W-1:0] cos_val, sin_val;
    logic signed [cma_pkg::SUM_W:0]  cos_acc, sin_acc;
    logic signed [cma_pkg::SUM_W:0]  cos_wide, sin_wide;
    logic [cma_pkg::SUM_W:0]         cos_abs, sin_abs;
    logic [45:0]                     mean_round;
    logic [13:0]                     mean_raw;
    logic [cma_pkg::MEAN_W-1:0]      mean_val;
    logic                            out_free;

    function automatic logic signed [cma_pkg::TRIG_W-1:0] to_trig(
        input logic signed [cma_pkg::XY_W-1:0] v,
        input logic                            flip
    );
        logic signed [cma_pkg::XY_W-1:0] lim;
        logic signed [cma_pkg::XY_W-1:0] r;
        lim = 64'sd1 <<< cma_pkg::TRIG_FRAC_BITS;
        r   = (v + (64'sd1 <<< (29 - cma_pkg::TRIG_FRAC_BITS)))
              >>> (30 - cma_pkg::TRIG_FRAC_BITS);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        if (flip)
            r = -r;
        return cma_pkg::TRIG_W'(r);
    endfunction

    // Shared CORDIC micro-rotation; rotation steers on z, vectoring on y
    assign dx      = y_reg >>> iter_reg;
    assign dy      = x_reg >>> iter_reg;
    assign arc     = $signed({4'b0000, cma_pkg::arc_angle(iter_reg)});
    assign turn_up = (state_reg == B_ROT) ? !z_reg[cma_pkg::Z_W-1] : y_reg[cma_pkg::XY_W-1];
    assign x_step  = turn_up ? x_reg - dx : x_reg + dx;
    assign y_step  = turn_up ? y_reg + dy : y_reg - dy;
    assign z_step  = turn_up ? z_reg - arc : z_reg + arc;
    assign iter_done = (iter_reg == cma_pkg::ITER_W'(cma_pkg::ITER_N - 1));

    assign z_fold = $signed({{(cma_pkg::Z_W-cma_pkg::PHASE_W){q_item.phase[cma_pkg::PHASE_W-1]}},
                             q_item.phase});

    assign cos_val = to_trig(x_reg, flip_reg);
    assign sin_val = to_trig(y_reg, flip_reg);
    assign cos_acc = {cos_sum_reg[cma_pkg::SUM_W-1], cos_sum_reg}
                     + (cma_pkg::SUM_W+1)'(cos_val);
    assign sin_acc = {sin_sum_reg[cma_pkg::SUM_W-1], sin_sum_reg}
                     + (cma_pkg::SUM_W+1)'(sin_val);

    assign cos_wide = {cos_sum_reg[cma_pkg::SUM_W-1], cos_sum_reg};
    assign sin_wide = {sin_sum_reg[cma_pkg::SUM_W-1], sin_sum_reg};
    assign cos_abs  = cos_wide[cma_pkg::SUM_W] ? (cma_pkg::SUM_W+1)'(-cos_wide) : cos_wide;
    assign sin_abs  = sin_wide[cma_pkg::SUM_W] ? (cma_pkg::SUM_W+1)'(-sin_wide) : sin_wide;

    assign mean_round = 46'(scaled_reg) + 46'h0_0080_0000_00;
    assign mean_raw   = mean_round[45:32];
    assign mean_val   = (mean_raw >= 14'(cma_pkg::FULL_TURN)) ? '0 : mean_raw[12:0];

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == B_IDLE) && !q_empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        flip_next      = flip_reg;
        iter_next      = iter_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        mag_next       = mag_reg;
        cos_sum_next   = cos_sum_reg;
        sin_sum_next   = sin_sum_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    last_next = q_item.last;
                    if (q_item.nodata)
                    begin
                        if (count_reg < cma_pkg::COUNT_CAP)
                            count_next = count_reg + 1'b1;
                        state_next = q_item.last ? B_LOAD : B_IDLE;
                    end
                    else
                    begin
                        // fold into [-90, 90] degrees, flip the sign for the back half
                        flip_next = 1'b0;
                        z_next    = z_fold;
                        if (z_fold > cma_pkg::QUARTER_TURN)
                        begin
                            z_next    = z_fold - cma_pkg::HALF_TURN;
                            flip_next = 1'b1;
                        end
                        else if (z_fold < -cma_pkg::QUARTER_TURN)
                        begin
                            z_next    = z_fold + cma_pkg::HALF_TURN;
                            flip_next = 1'b1;
                        end
                        x_next     = cma_pkg::CORDIC_START;
                        y_next     = '0;
                        iter_next  = '0;
                        state_next = B_ROT;
                    end
                end
            end
            B_ROT, B_VEC:
            begin
                x_next    = x_step;
                y_next    = y_step;
                z_next    = z_step;
                iter_next = iter_reg + 1'b1;
                if (iter_done)
                    state_next = (state_reg == B_ROT) ? B_ACC : B_SCALE;
            end
            B_ACC:
            begin
                if (cos_acc > SUM_MAX)
                    cos_sum_next = cma_pkg::SUM_W'(SUM_MAX);
                else if (cos_acc < SUM_MIN)
                    cos_sum_next = cma_pkg::SUM_W'(SUM_MIN);
                else
                    cos_sum_next = cma_pkg::SUM_W'(cos_acc);
                if (sin_acc > SUM_MAX)
                    sin_sum_next = cma_pkg::SUM_W'(SUM_MAX);
                else if (sin_acc < SUM_MIN)
                    sin_sum_next = cma_pkg::SUM_W'(SUM_MIN);
                else
                    sin_sum_next = cma_pkg::SUM_W'(sin_acc);
                state_next = last_reg ? B_LOAD : B_IDLE;
            end
            B_LOAD:
            begin
                x_next   = cma_pkg::XY_W'(cos_sum_reg);
                y_next   = cma_pkg::XY_W'(sin_sum_reg);
                z_next   = '0;
                mag_next = (cos_abs > sin_abs) ? cma_pkg::MAG_W'(cos_abs)
                                               : cma_pkg::MAG_W'(sin_abs);
                // zero vector: skip straight to a zero phase
                state_next = (cos_sum_reg == '0 && sin_sum_reg == '0) ? B_SCALE : B_NORM;
            end
            B_NORM:
            begin
                if (mag_reg[cma_pkg::MAG_W-1])
                begin
                    if (x_reg[cma_pkg::XY_W-1])
                    begin
                        x_next = -x_reg;
                        y_next = -y_reg;
                        z_next = cma_pkg::HALF_TURN;
                    end
                    iter_next  = '0;
                    state_next = B_VEC;
                end
                else if (mag_reg[cma_pkg::MAG_W-1 -: 8] == '0)
                begin
                    x_next   = x_reg <<< 8;
                    y_next   = y_reg <<< 8;
                    mag_next = mag_reg << 8;
                end
                else
                begin
                    x_next   = x_reg <<< 1;
                    y_next   = y_reg <<< 1;
                    mag_next = mag_reg << 1;
                end
            end
            B_SCALE:
                state_next = B_FIN;
            B_FIN:
            begin
                // hold here until the output register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    cos_sum_next   = '0;
                    sin_sum_next   = '0;
                    count_next     = '0;
                    state_next     = B_IDLE;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            last_reg      <= 1'b0;
            cos_sum_reg   <= '0;
            sin_sum_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            cos_sum_reg   <= cos_sum_next;
            sin_sum_reg   <= sin_sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flip_reg <= flip_next;
        iter_reg <= iter_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        mag_reg  <= mag_next;
        if (state_reg == B_SCALE)
            scaled_reg <= 45'(z_reg[cma_pkg::PHASE_W-1:0]) * 45'd5760;
        if (state_reg == B_FIN && out_free)
            out_data_reg <= {6'b0, count_reg, mean_val};
    end

endmodule

/* rtl/circular_mean_of_angles.sv */
// Circular mean of a stream of angles: top level joining front end, queue and
// CORDIC back end. Depends on cma_pkg, cma_front, cma_fifo, cma_back.
//
// Usage:
//   s_tdata[19:0] carries one signed angle in sixteenths of a degree per word;
//   s_tlast marks the last word of a region. A word equal to the no-data code
//   (written through cfg_we/cfg_data, reset value -159984) is only counted.
//   After the last word, one result word leaves on m_tdata: mean_angle in
//   [12:0] (0..5759 sixteenths of a degree) and the saturating no-data count
//   in [33:13]; the sums and count then clear for the next region.
// Flow:
//   The front end takes a word only when idle, reduces it modulo a full turn,
//   turns it into a phase and pushes it into the queue before it takes the next.
//   The back end pops a data word, runs 17 CORDIC iterations and accumulates;
//   a no-data word is only counted. The shared CORDIC sets the sustained rate.
//   A last word adds normalization, 17 vectoring iterations, scaling and the
//   output load; a region whose sums are both zero skips normalization and vectoring.
// Reset clears the sums, the count, the queue and the output valid flag, and
// restores the no-data code. When m_tready is low the result holds in the
// output register; the back end keeps consuming queued words and stalls only
// when a second result is ready, and then the 4-word queue fills and s_tready
// drops.
module circular_mean_of_angles (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // [19:0] angle_sample, zero fill above
    input  logic                          s_tlast,   // last_sample
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // [12:0] mean_angle, [33:13] nodata_count
    input  logic                          cfg_we,
    input  logic [cma_pkg::ANGLE_W-1:0]   cfg_data   // nodata_code
);

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    cma_pkg::cma_item_t q_in;
    cma_pkg::cma_item_t q_out;

    cma_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .push      (q_push),
        .push_item (q_in),
        .q_full    (q_full)
    );

    cma_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out),
        .empty     (q_empty)
    );

    cma_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_out),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("queue read while empty");

    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[12:0] < 13'd5760))
        else $error("mean angle outside a full turn");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[33:13] <= cma_pkg::COUNT_CAP))
        else $error("no-data count above its cap");

endmodule

/* tb/circular_mean_checker.sv */
// Checker for circular_mean_of_angles: watches the input, output and config ports,
// predicts each region's mean direction and no-data count, and compares.
// Depends on cma_pkg for the widths and the reset no-data code.
`timescale 1ns / 100ps

module circular_mean_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // [19:0] angle_sample, zero fill above
    input  logic                        s_tlast,   // last_sample
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [39:0]                 m_tdata,   // [12:0] mean_angle, [33:13] nodata_count
    input  logic                        cfg_we,
    input  logic [cma_pkg::ANGLE_W-1:0] cfg_data,
    output int                          fail_count,
    output int                          pending
);

    localparam int     FRAC      = cma_pkg::TRIG_FRAC_BITS;
    localparam int     STEPS     = cma_pkg::ITER_N;
    localparam longint TURN_16TH = 5760;
    localparam longint HALF      = 64'sd2147483648;
    localparam longint QUARTER   = 64'sd1073741824;
    localparam longint ROT_START = 64'sd652032874;
    localparam longint ACC_MAX   = (64'sd1 <<< 36) - 1;
    localparam longint ACC_MIN   = -(64'sd1 <<< 36);
    localparam int     SKIP_CAP  = int'(cma_pkg::COUNT_CAP);

    typedef struct {
        logic [cma_pkg::MEAN_W-1:0]  mean;
        logic [cma_pkg::COUNT_W-1:0] skipped;
    } region_result_t;

    // atan(2^-i) in units of 2^-32 turn
    longint arc_turn [26] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20
    };

    region_result_t              region_q [$];
    logic [cma_pkg::ANGLE_W-1:0] nodata_code;
    longint                      cos_total;
    longint                      sin_total;
    int                          skip_total;

    initial fail_count = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic longint trig_round(input longint v, input bit flip);
        longint lim;
        longint r;
        lim = 64'sd1 <<< FRAC;
        r = (v + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return flip ? -r : r;
    endfunction

    // cos/sin of one sample by CORDIC rotation, folded into the front half-plane
    task automatic sample_trig(input logic [cma_pkg::ANGLE_W-1:0] raw, output longint c,
                               output longint s);
        longint            a;
        longint unsigned   au;
        longint unsigned   ph;
        longint            x;
        longint            y;
        longint            z;
        longint            dx;
        longint            dy;
        bit                flip;
        a = {{44{raw[cma_pkg::ANGLE_W-1]}}, raw};
        a = a % TURN_16TH;
        if (a < 0)
            a += TURN_16TH;
        au = a;
        ph = ((au << 32) + 64'd2880) / 64'd5760;
        z = ph & 64'hFFFF_FFFF;
        x = ROT_START;
        y = 0;
        flip = 1'b0;
        if (z >= HALF)
            z -= 2 * HALF;
        if (z > QUARTER)
        begin
            z -= HALF;
            flip = 1'b1;
        end
        else if (z < -QUARTER)
        begin
            z += HALF;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arc_turn[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arc_turn[i];
            end
        end
        c = trig_round(x, flip);
        s = trig_round(y, flip);
    endtask

    // direction of (x, y) in units of 2^-32 turn, by CORDIC vectoring
    function automatic longint unsigned vector_turn(input longint x, input longint y);
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned m;
        longint          z;
        longint          dx;
        longint          dy;
        int              sh;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        m = (ax > ay) ? ax : ay;
        z = 0;
        sh = 0;
        if (m == 0)
            return 0;
        while (m < (64'd1 << 59))
        begin
            m = m << 1;
            sh++;
        end
        x = x <<< sh;
        y = y <<< sh;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = HALF;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += arc_turn[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= arc_turn[i];
            end
        end
        return longint'(z) & 64'hFFFF_FFFF;
    endfunction

    task automatic absorb_word(input logic [cma_pkg::ANGLE_W-1:0] raw, input logic lst);
        longint          c;
        longint          s;
        longint unsigned ph;
        longint unsigned t;
        region_result_t  res;
        // raw compare, before any reduction
        if (raw == nodata_code)
        begin
            if (skip_total < SKIP_CAP)
                skip_total++;
        end
        else
        begin
            sample_trig(raw, c, s);
            cos_total += c;
            sin_total += s;
            if (cos_total > ACC_MAX)
                cos_total = ACC_MAX;
            if (cos_total < ACC_MIN)
                cos_total = ACC_MIN;
            if (sin_total > ACC_MAX)
                sin_total = ACC_MAX;
            if (sin_total < ACC_MIN)
                sin_total = ACC_MIN;
        end
        if (lst)
        begin
            ph = vector_turn(cos_total, sin_total);
            t = (ph * 64'd5760 + (64'd1 << 31)) >> 32;
            if (t >= 64'd5760)
                t = 0;
            res.mean = cma_pkg::MEAN_W'(t);
            res.skipped = cma_pkg::COUNT_W'(skip_total);
            region_q = {region_q, res};
            cos_total = 0;
            sin_total = 0;
            skip_total = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        region_result_t want;
        if (!rst_n)
        begin
            nodata_code = cma_pkg::NODATA_RESET;
            cos_total = 0;
            sin_total = 0;
            skip_total = 0;
            region_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (region_q.size() == 0)
                    report_mismatch($sformatf("result word with none expected: %h", m_tdata));
                else
                begin
                    want = region_q.pop_front();
                    if (m_tdata[12:0] != want.mean)
                        report_mismatch($sformatf("mean_angle got %0d expected %0d",
                                                  m_tdata[12:0], want.mean));
                    if (m_tdata[33:13] != want.skipped)
                        report_mismatch($sformatf("nodata_count got %0d expected %0d",
                                                  m_tdata[33:13], want.skipped));
                end
            end
            if (cfg_we)
                nodata_code = cfg_data;
            if (s_tvalid && s_tready)
                absorb_word(s_tdata[cma_pkg::ANGLE_W-1:0], s_tlast);
        end
        pending = region_q.size();
    end

endmodule

/* tb/tb_circular_mean_of_angles.sv */
// Top of the circular_mean_of_angles testbench: clock, reset, stimulus and verdict.
// Depends on cma_pkg, the circular_mean_of_angles RTL and circular_mean_checker.
`timescale 1ns / 100ps

module tb_circular_mean_of_angles;

    localparam int              TURN        = 5760;
    localparam logic [19:0]     ANGLE_MIN   = 20'h80000;
    localparam logic [19:0]     ANGLE_MAX   = 20'h7FFFF;
    localparam int              SETTLE      = 64;
    localparam int              HOLD_CYCLES = 600;
    localparam int              IDLE_LIMIT  = 3000;
    localparam int              PHASE_WORDS = 230;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [19:0] angle_sample, zero fill above
    logic        s_tlast;   // last_sample
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [12:0] mean_angle, [33:13] nodata_count
    logic        cfg_we;
    logic [19:0] cfg_data;

    int          fail_count;
    int          pending;
    logic        s_fire = 1'b0;
    logic        m_fire = 1'b0;
    int          idle_cycles = 0;
    int          tx_gap_max;
    int          rx_gap_max;
    bit          hold_req;
    logic [19:0] nodata_now;

    circular_mean_of_angles uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    circular_mean_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // handshake flags from pre-edge values, read at the following falling edge
    always @(posedge clk)
    begin
        s_fire <= s_tvalid & s_tready;
        m_fire <= m_tvalid & m_tready;
    end

    always @(negedge clk)
    begin
        if (s_fire || m_fire)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int n;
        m_tready = 1'b0;
        while (rst_n !== 1'b1)
            @(negedge clk);
        forever
        begin
            n = $urandom_range(0, rx_gap_max);
            if (hold_req)
            begin
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (n > 0)
            begin
                m_tready = 1'b0;
                if (n < HOLD_CYCLES && $urandom_range(0, 1))
                    while (!m_tvalid && !hold_req)
                        @(negedge clk);
                repeat (n) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(negedge clk);
            while (!m_fire && !hold_req);
        end
    end

    task automatic send_word(input logic [19:0] ang, input logic lst);
        int n;
        n = $urandom_range(0, tx_gap_max);
        if (n > 0)
        begin
            s_tvalid = 1'b0;
            repeat (n) @(negedge clk);
        end
        s_tdata = {4'b0, ang};
        s_tlast = lst;
        s_tvalid = 1'b1;
        do
            @(negedge clk);
        while (!s_fire);
    endtask

    // drop valid, wait for every expected result, then let the back end settle
    task automatic drain_results;
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_nodata(input logic [19:0] code);
        cfg_data = code;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        nodata_now = code;
    endtask

    function automatic logic [19:0] pick_angle(input int base, input int spread);
        int sel;
        int v;
        sel = $urandom_range(0, 15);
        if (sel < 2)
            return nodata_now;
        if (sel < 5)
            return 20'($urandom);
        if (sel == 5)
        begin
            case ($urandom_range(0, 3))
                0:       return ANGLE_MIN;
                1:       return ANGLE_MAX;
                2:       return 20'd0;
                default: return 20'(TURN - 1);
            endcase
        end
        v = base + int'($urandom_range(0, spread)) - spread / 2;
        // add whole turns now and then so reduction is exercised
        if (sel > 12)
            v += TURN * (int'($urandom_range(0, 8)) - 4);
        return 20'(v);
    endfunction

    task automatic run_regions(input int words);
        int done;
        int len;
        int base;
        int spread;
        done = 0;
        while (done < words)
        begin
            if ($urandom_range(0, 9) < 8)
                len = $urandom_range(1, 8);
            else
                len = $urandom_range(9, 30);
            base = $urandom_range(0, TURN - 1);
            case ($urandom_range(0, 3))
                0:       spread = 16;
                1:       spread = 400;
                2:       spread = 2880;
                default: spread = TURN;
            endcase
            for (int k = 0; k < len; k++)
                send_word(pick_angle(base, spread), k == len - 1);
            done += len;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        nodata_now = cma_pkg::NODATA_RESET;
        tx_gap_max = 14;
        rx_gap_max = 14;
        hold_req = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // field extremes, wrap-around angles and one no-data word under the reset code
        send_word(20'd0, 1'b0);
        send_word(20'(TURN - 1), 1'b0);
        send_word(ANGLE_MIN, 1'b0);
        send_word(ANGLE_MAX, 1'b0);
        send_word(20'(TURN), 1'b0);
        send_word(20'hFFFFF, 1'b0);
        send_word(cma_pkg::NODATA_RESET, 1'b0);
        send_word(20'd1440, 1'b1);
        // region of only no-data words
        send_word(cma_pkg::NODATA_RESET, 1'b0);
        send_word(cma_pkg::NODATA_RESET, 1'b1);
        // single data word
        send_word(20'd2880, 1'b1);
        // opposite vectors cancel to zero
        send_word(20'd0, 1'b0);
        send_word(20'd2880, 1'b1);
        // means right at the top of the range, rounding up to a full turn
        send_word(20'(TURN - 1), 1'b0);
        send_word(20'd1, 1'b1);
        send_word(20'(TURN - 2), 1'b0);
        send_word(20'd1, 1'b1);
        drain_results();

        // no-data compare is on the raw word: 5760 is data even when code is 0
        write_nodata(20'd0);
        send_word(20'(TURN), 1'b0);
        send_word(20'd0, 1'b0);
        send_word(20'(-TURN), 1'b1);

        tx_gap_max = 14;
        rx_gap_max = 14;
        run_regions(PHASE_WORDS);
        drain_results();

        write_nodata(ANGLE_MAX);
        // hold the result side while short regions keep coming, so the queue fills
        tx_gap_max = 0;
        hold_req = 1'b1;
        for (int r = 0; r < 10; r++)
        begin
            send_word(pick_angle(1000, 400), 1'b0);
            send_word(pick_angle(1000, 400), 1'b1);
        end
        drain_results();
        rx_gap_max = 0;
        run_regions(PHASE_WORDS);
        drain_results();

        write_nodata(ANGLE_MIN);
        tx_gap_max = 14;
        rx_gap_max = 0;
        run_regions(PHASE_WORDS);
        drain_results();

        write_nodata(20'($urandom));
        tx_gap_max = 0;
        rx_gap_max = 14;
        run_regions(PHASE_WORDS);
        drain_results();

        write_nodata(cma_pkg::NODATA_RESET);
        tx_gap_max = 3;
        rx_gap_max = 7;
        run_regions(PHASE_WORDS);
        drain_results();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
